// File: rtl/core/ma3_pkg.sv
// ----------------------------------------------------------------------------
// ma3_pkg: shared widths for the 3x3 matrix inverse
// Element, product, cofactor, determinant and quotient widths; all but the
// 48-bit output width derive from the element width and the fraction bits.
// ----------------------------------------------------------------------------
package ma3_pkg;

   localparam int ELEM_W    = 16;                  // matrix element
   localparam int FRAC_W    = 16;                  // fraction bits of the inverse
   localparam int PROD_W    = 2 * ELEM_W;          // element x element
   localparam int COF_W     = PROD_W + 1;          // difference of two products
   localparam int DPROD_W   = ELEM_W + COF_W;      // element x cofactor
   localparam int DET_W     = 3 * ELEM_W + 1;      // determinant, signed
   localparam int DMAG_W    = DET_W;               // determinant magnitude
   localparam int NUM_W     = COF_W + FRAC_W;      // scaled cofactor magnitude
   localparam int REM_W     = DMAG_W + 1;          // partial remainder
   localparam int OUT_W     = 48;                  // inverse element
   localparam int DIV_STEPS = NUM_W;               // one quotient bit per stage
   localparam int PRE_STAGES = 6;                  // input, product, cofactor,
                                                   // det product, det sum, magnitude

endpackage

// File: rtl/core/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 integer matrix inverse by the adjugate
// One matrix per transfer in, one inverse per transfer out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: the block takes one matrix per clock and returns one result per
// clock in the same order while the output is not stalled. Six stages
// form products, cofactors and the determinant, the 49-stage restoring
// divider produces one quotient bit per stage, and an output register
// holds the result. Nine cofactor lanes work side by side,
// the determinant stage merges row 0 of the matrix with three of them, and
// nine divider lanes share one pipelined copy of the determinant magnitude.
// The whole pipeline advances when the output register is empty or is being
// taken, so a stalled consumer holds everything in place. Each inverse
// element is adj(r,c) * 2^16 / det truncated toward zero and saturated to
// 48 bits; for a zero determinant the inverse is all zeros and singular is set.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
   input  logic         clock,
   input  logic         reset,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
   input  logic [143:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // inv00..inv22 (48 bits each), det_value (49 bits), 7 zero pad bits
   output logic [487:0] rsp_tdata,
   // singular
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   localparam int EW     = ma3_pkg::ELEM_W;
   localparam int STEPS  = ma3_pkg::DIV_STEPS;
   localparam int NVALID = ma3_pkg::PRE_STAGES + STEPS;

   // pipeline advance: output register free or being emptied this cycle
   logic adv;
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   // ---- valid tracking ---------------------------------------------------
   logic [NVALID-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[NVALID-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // ---- input register ---------------------------------------------------
   logic signed [EW-1:0] m_ff [0:8];
   logic signed [EW-1:0] r0a_ff [0:2];   // row 0, aligned with the products

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= req_tdata[k*EW +: EW];
         end
         for (int k = 0; k < 3; k++) begin
            r0a_ff[k] <= m_ff[k];
         end
      end
   end

   logic signed [EW-1:0] r0b_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            r0b_ff[k] <= r0a_ff[k];
         end
      end
   end

   // ---- cofactor lanes ---------------------------------------------------
   // lane k holds adjugate entry (k/3, k%3); index into m_ff is row*3+col
   logic signed [ma3_pkg::COF_W-1:0] adj [0:8];

   ma3_cofactor u_cof00 (.clock, .adv, .x0(m_ff[4]), .x1(m_ff[8]),
                         .x2(m_ff[5]), .x3(m_ff[7]), .cof(adj[0]));
   ma3_cofactor u_cof01 (.clock, .adv, .x0(m_ff[2]), .x1(m_ff[7]),
                         .x2(m_ff[1]), .x3(m_ff[8]), .cof(adj[1]));
   ma3_cofactor u_cof02 (.clock, .adv, .x0(m_ff[1]), .x1(m_ff[5]),
                         .x2(m_ff[2]), .x3(m_ff[4]), .cof(adj[2]));
   ma3_cofactor u_cof10 (.clock, .adv, .x0(m_ff[5]), .x1(m_ff[6]),
                         .x2(m_ff[3]), .x3(m_ff[8]), .cof(adj[3]));
   ma3_cofactor u_cof11 (.clock, .adv, .x0(m_ff[0]), .x1(m_ff[8]),
                         .x2(m_ff[2]), .x3(m_ff[6]), .cof(adj[4]));
   ma3_cofactor u_cof12 (.clock, .adv, .x0(m_ff[2]), .x1(m_ff[3]),
                         .x2(m_ff[0]), .x3(m_ff[5]), .cof(adj[5]));
   ma3_cofactor u_cof20 (.clock, .adv, .x0(m_ff[3]), .x1(m_ff[7]),
                         .x2(m_ff[4]), .x3(m_ff[6]), .cof(adj[6]));
   ma3_cofactor u_cof21 (.clock, .adv, .x0(m_ff[1]), .x1(m_ff[6]),
                         .x2(m_ff[0]), .x3(m_ff[7]), .cof(adj[7]));
   ma3_cofactor u_cof22 (.clock, .adv, .x0(m_ff[0]), .x1(m_ff[4]),
                         .x2(m_ff[1]), .x3(m_ff[3]), .cof(adj[8]));

   // ---- determinant merge ------------------------------------------------
   logic signed [ma3_pkg::DET_W-1:0] det0;
   logic [ma3_pkg::DMAG_W-1:0]       dmag0;
   logic                             dneg0, dzero0;

   ma3_det u_det (
      .clock, .adv,
      .m00(r0b_ff[0]), .m01(r0b_ff[1]), .m02(r0b_ff[2]),
      .a00(adj[0]), .a10(adj[3]), .a20(adj[6]),
      .det(det0), .dmag(dmag0), .dneg(dneg0), .dzero(dzero0)
   );

   // ---- determinant side pipe, aligned with the divider stages ----------
   logic [STEPS-1:0][ma3_pkg::DMAG_W-1:0] dmag_pipe;
   logic [ma3_pkg::DMAG_W-1:0]            dmag_ff [1:STEPS-1];
   logic signed [ma3_pkg::DET_W-1:0]      det_ff [1:STEPS];
   logic [STEPS:1]                        dneg_ff, dzero_ff;

   assign dmag_pipe[0] = dmag0;
   for (genvar j = 1; j < STEPS; j++) begin : g_dmag
      assign dmag_pipe[j] = dmag_ff[j];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff[1]  <= dmag0;
         for (int j = 2; j < STEPS; j++) begin
            dmag_ff[j] <= dmag_ff[j-1];
         end
         det_ff[1]   <= det0;
         dneg_ff[1]  <= dneg0;
         dzero_ff[1] <= dzero0;
         for (int j = 2; j <= STEPS; j++) begin
            det_ff[j]   <= det_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dzero_ff[j] <= dzero_ff[j-1];
         end
      end
   end

   // ---- divider lanes ----------------------------------------------------
   logic [ma3_pkg::OUT_W-1:0] inv [0:8];

   for (genvar k = 0; k < 9; k++) begin : g_div
      ma3_div_lane u_div (
         .clock, .adv,
         .cof(adj[k]),
         .dmag_pipe,
         .dneg_last(dneg_ff[STEPS]),
         .dzero_last(dzero_ff[STEPS]),
         .inv(inv[k])
      );
   end

   // ---- output register --------------------------------------------------
   logic [487:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff;
   logic         rsp_valid_ff;

   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < 9; k++) begin
         rsp_data_in[k*ma3_pkg::OUT_W +: ma3_pkg::OUT_W] = inv[k];
      end
      rsp_data_in[9*ma3_pkg::OUT_W +: ma3_pkg::DET_W] = det_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[NVALID-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= dzero_ff[STEPS];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // ---- assertions -------------------------------------------------------
   // singular result carries a zero determinant and a zero inverse
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[480:0] == '0)
      else $error("singular result with nonzero payload");

   // a nonsingular result never reports a zero determinant
   a_nonsingular_det : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[480:432] != '0)
      else $error("nonsingular result with zero determinant");

   // a stalled output freezes the pipeline: nothing new is taken in
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output is stalled");

   // an item at the end of the pipe reaches the output register
   a_drain : assert property (@(posedge clock) disable iff (reset)
      adv && valid_ff[NVALID-1] |=> rsp_tvalid)
      else $error("finished item lost before the output register");

endmodule

// File: rtl/core/ma3_cofactor.sv
// ----------------------------------------------------------------------------
// ma3_cofactor: one adjugate lane
// Forms x0*x1 - x2*x3 over two register stages.
// ----------------------------------------------------------------------------
module ma3_cofactor (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [ma3_pkg::ELEM_W-1:0] x0,
   input  logic signed [ma3_pkg::ELEM_W-1:0] x1,
   input  logic signed [ma3_pkg::ELEM_W-1:0] x2,
   input  logic signed [ma3_pkg::ELEM_W-1:0] x3,
   output logic signed [ma3_pkg::COF_W-1:0]  cof
);

   logic signed [ma3_pkg::PROD_W-1:0] p0_ff, p1_ff;
   logic signed [ma3_pkg::COF_W-1:0]  cof_ff, cof_in;

   assign cof_in = ma3_pkg::COF_W'(p0_ff) - ma3_pkg::COF_W'(p1_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff  <= x0 * x1;
         p1_ff  <= x2 * x3;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

// File: rtl/core/ma3_det.sv
// ----------------------------------------------------------------------------
// ma3_det: determinant merge
// Combines first-row elements with the lane cofactors, then splits the
// determinant into magnitude, sign and zero flag.
// ----------------------------------------------------------------------------
module ma3_det (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [ma3_pkg::ELEM_W-1:0] m00,
   input  logic signed [ma3_pkg::ELEM_W-1:0] m01,
   input  logic signed [ma3_pkg::ELEM_W-1:0] m02,
   input  logic signed [ma3_pkg::COF_W-1:0]  a00,
   input  logic signed [ma3_pkg::COF_W-1:0]  a10,
   input  logic signed [ma3_pkg::COF_W-1:0]  a20,
   output logic signed [ma3_pkg::DET_W-1:0]  det,
   output logic        [ma3_pkg::DMAG_W-1:0] dmag,
   output logic                              dneg,
   output logic                              dzero
);

   logic signed [ma3_pkg::DPROD_W-1:0] t0_ff, t1_ff, t2_ff;
   logic signed [ma3_pkg::DET_W-1:0]   sum_ff, sum_in;
   logic signed [ma3_pkg::DET_W-1:0]   det_ff;
   logic        [ma3_pkg::DMAG_W-1:0]  dmag_ff, dmag_in;
   logic                               dneg_ff, dzero_ff;

   assign sum_in  = ma3_pkg::DET_W'(t0_ff) + ma3_pkg::DET_W'(t1_ff)
                  + ma3_pkg::DET_W'(t2_ff);
   assign dmag_in = sum_ff[ma3_pkg::DET_W-1] ? ma3_pkg::DMAG_W'(-sum_ff)
                                             : ma3_pkg::DMAG_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff    <= m00 * a00;
         t1_ff    <= m01 * a10;
         t2_ff    <= m02 * a20;
         sum_ff   <= sum_in;
         det_ff   <= sum_ff;
         dmag_ff  <= dmag_in;
         dneg_ff  <= sum_ff[ma3_pkg::DET_W-1];
         dzero_ff <= (sum_ff == '0);
      end
   end

   assign det   = det_ff;
   assign dmag  = dmag_ff;
   assign dneg  = dneg_ff;
   assign dzero = dzero_ff;

endmodule

// File: rtl/core/ma3_div_lane.sv
// ----------------------------------------------------------------------------
// ma3_div_lane: scaled cofactor / determinant for one lane
// Aligns the cofactor with the determinant, then runs a restoring divider
// with one quotient bit per stage; signs and saturates the final quotient.
// ----------------------------------------------------------------------------
module ma3_div_lane (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [ma3_pkg::COF_W-1:0]    cof,
   input  logic [ma3_pkg::DIV_STEPS-1:0][ma3_pkg::DMAG_W-1:0] dmag_pipe,
   input  logic                                dneg_last,
   input  logic                                dzero_last,
   output logic [ma3_pkg::OUT_W-1:0]           inv
);

   localparam int STEPS = ma3_pkg::DIV_STEPS;
   localparam int NW    = ma3_pkg::NUM_W;
   localparam int RW    = ma3_pkg::REM_W;

   logic signed [ma3_pkg::COF_W-1:0] c4_ff, c5_ff;
   logic [NW-1:0]  n_ff [0:STEPS-1];
   logic [RW-1:0]  r_ff [1:STEPS-1];
   logic [NW-1:0]  q_ff [1:STEPS];
   logic           cneg_ff [0:STEPS];
   logic [NW-1:0]  num_in;
   logic [ma3_pkg::COF_W-1:0] cmag;

   assign cmag   = c5_ff[ma3_pkg::COF_W-1] ? ma3_pkg::COF_W'(-c5_ff)
                                           : ma3_pkg::COF_W'(c5_ff);
   assign num_in = {cmag, {ma3_pkg::FRAC_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff      <= cof;
         c5_ff      <= c4_ff;
         n_ff[0]    <= num_in;
         cneg_ff[0] <= c5_ff[ma3_pkg::COF_W-1];
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [RW-1:0] r_cur, r_sh;
      logic [NW-1:0] q_cur, q_in;
      logic [RW:0]   diff;
      logic          ge;

      if (j == 0) begin : g_first
         assign r_cur = '0;
         assign q_cur = '0;
      end else begin : g_rest
         assign r_cur = r_ff[j];
         assign q_cur = q_ff[j];
      end

      assign r_sh = {r_cur[RW-2:0], n_ff[j][NW-1]};
      assign diff = {1'b0, r_sh} - {2'b00, dmag_pipe[j]};
      assign ge   = ~diff[RW];
      assign q_in = {q_cur[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[j+1]    <= q_in;
            cneg_ff[j+1] <= cneg_ff[j];
         end
      end

      // the last stage only needs its quotient bit
      if (j < STEPS - 1) begin : g_shift
         logic [RW-1:0] r_in;
         assign r_in = ge ? diff[RW-1:0] : r_sh;

         always_ff @(posedge clock) begin
            if (adv) begin
               n_ff[j+1] <= {n_ff[j][NW-2:0], 1'b0};
               r_ff[j+1] <= r_in;
            end
         end
      end
   end

   // saturate to the signed output range, then apply the sign
   logic          neg;
   logic [NW-1:0] lim, qsat, qsgn;

   assign neg  = cneg_ff[STEPS] ^ dneg_last;
   assign lim  = neg ? (NW'(1) << (ma3_pkg::OUT_W - 1))
                     : ((NW'(1) << (ma3_pkg::OUT_W - 1)) - NW'(1));
   assign qsat = (q_ff[STEPS] > lim) ? lim : q_ff[STEPS];
   assign qsgn = neg ? (~qsat + NW'(1)) : qsat;
   assign inv  = dzero_last ? '0 : qsgn[ma3_pkg::OUT_W-1:0];

endmodule

// File: dv/matrix_inverse_checker.sv
// ----------------------------------------------------------------------------
// matrix_inverse_checker: result predictor and comparator
// Watches both streams, computes the expected inverse of every matrix
// accepted, and compares each returned inverse field by field in order.
// ----------------------------------------------------------------------------
module matrix_inverse_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic [143:0] req_tdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [487:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   output int           fail_count,
   output int           pending_count
);

   typedef struct {
      logic [487:0] data;
      logic         singular;
   } inverse_type;

   inverse_type inverse_q[$];
   int          mismatch_count;

   initial pending_count = 0;

   // truncating divide of cof * 2^16 by det, saturated to 48 bits
   function automatic logic [47:0] scaled_quotient(longint signed cof,
                                                   logic signed [127:0] det);
      logic signed [127:0] num, q;
      logic signed [127:0] pmax, nmin;
      num  = 128'(cof) <<< 16;
      q    = num / det;                  // SV division truncates toward zero
      pmax = (128'sd1 <<< 47) - 1;
      nmin = -(128'sd1 <<< 47);
      if (q > pmax) q = pmax;
      if (q < nmin) q = nmin;
      return q[47:0];
   endfunction

   function automatic inverse_type predict_inverse(logic [143:0] d);
      longint signed m[9];
      longint signed cof[9];
      logic signed [127:0] det;
      inverse_type r;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
      cof[0] = m[4]*m[8] - m[5]*m[7];
      cof[1] = m[2]*m[7] - m[1]*m[8];
      cof[2] = m[1]*m[5] - m[2]*m[4];
      cof[3] = m[5]*m[6] - m[3]*m[8];
      cof[4] = m[0]*m[8] - m[2]*m[6];
      cof[5] = m[2]*m[3] - m[0]*m[5];
      cof[6] = m[3]*m[7] - m[4]*m[6];
      cof[7] = m[1]*m[6] - m[0]*m[7];
      cof[8] = m[0]*m[4] - m[1]*m[3];
      det = 128'(m[0])*128'(cof[0]) + 128'(m[1])*128'(cof[3])
            + 128'(m[2])*128'(cof[6]);
      r.data = '0;
      r.singular = (det == 0);
      if (!r.singular) begin
         for (int i = 0; i < 9; i++) r.data[48*i +: 48] = scaled_quotient(cof[i], det);
         r.data[432 +: 49] = det[48:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      inverse_type exp_r;
      if (reset) begin
         fail_count     <= 0;
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) inverse_q.push_back(predict_inverse(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (inverse_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (mismatch_count < 10) $display("unexpected inverse %h", rsp_tdata);
               mismatch_count++;
            end else begin
               exp_r = inverse_q.pop_front();
               if (exp_r.data !== rsp_tdata || exp_r.singular !== rsp_tuser) begin
                  fail_count <= fail_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: exp %h/%b got %h/%b", exp_r.data,
                              exp_r.singular, rsp_tdata, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = inverse_q.size();
   end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: stream test of the 3x3 matrix inverse
// Directed extreme and singular matrices, then random ones of mixed
// magnitude, with random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY   = 56;
   localparam int NUM_RAND  = 2000;
   localparam int IDLE_MAX  = 5000;

   logic         clock = 0;
   logic         reset = 1;
   logic [143:0] req_tdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [487:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   int           fail_count, pending_count;
   int           idle_cycles = 0;
   bit           stim_started = 0;
   bit           hold_off = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   matrix_inverse_3x3 dut (.*);

   matrix_inverse_checker chk (.*);

   // random gap length: mostly short, sometimes long
   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // one element: full range, small, or an extreme
   function automatic logic [15:0] rand_elem(int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 14)) - 7);
         default: case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
         endcase
      endcase
   endfunction

   function automatic logic [143:0] rand_matrix();
      logic [143:0] d;
      int style;
      style = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) d[16*i +: 16] = rand_elem(style);
      if ($urandom_range(0, 9) == 0)                    // dependent rows: singular
         d[96 +: 48] = d[0 +: 48];
      if ($urandom_range(0, 9) == 0) begin              // unimodular-ish: big quotient
         d = '0;
         d[0 +: 16] = 1; d[64 +: 16] = 1; d[128 +: 16] = 1;
         d[16 +: 16] = rand_elem(0); d[32 +: 16] = rand_elem(0);
         d[80 +: 16] = rand_elem(0);
      end
      return d;
   endfunction

   // offer one matrix and hold it until it is taken; valid drops only for a gap
   task automatic send(logic [143:0] d, bit burst);
      int g;
      g = burst ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tdata  <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off early in the random part
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
   end

   initial begin
      @(posedge clock);
      wait (stim_started);
      repeat (40) @(posedge clock);
      hold_off <= 1;
      repeat (300) @(posedge clock);
      hold_off <= 0;
   end

   // watchdog on accepted transfers
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [143:0] d;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: identity, zero, extremes, all ones, singular, unit-ish
      d = '0; d[0 +: 16] = 1; d[64 +: 16] = 1; d[128 +: 16] = 1; send(d, 0);
      send('0, 0);
      send({9{16'h8000}}, 0);
      send({9{16'h7fff}}, 0);
      send({9{16'hffff}}, 0);
      d = '0; d[0 +: 16] = 16'h8000; d[64 +: 16] = 16'h8000; d[128 +: 16] = 16'h8000;
      send(d, 0);
      d = '0; d[0 +: 16] = 16'h7fff; d[64 +: 16] = 16'h8000; d[128 +: 16] = 16'h7fff;
      send(d, 0);
      d = '0; d[0 +: 16] = 16'h8000; d[48 +: 16] = 16'h7fff; d[96 +: 16] = 16'h7fff;
      d[16 +: 16] = 16'h7fff; d[64 +: 16] = 16'h8000; d[112 +: 16] = 16'h7fff;
      d[32 +: 16] = 16'h7fff; d[80 +: 16] = 16'h7fff; d[128 +: 16] = 16'h8000; send(d, 0);
      // det 1 with large cofactors: large quotients, still within 48 bits
      d = '0; d[0 +: 16] = 1; d[64 +: 16] = 1; d[128 +: 16] = 1;
      d[16 +: 16] = 16'h7fff; d[80 +: 16] = 16'h8000; d[32 +: 16] = 16'h7fff; send(d, 0);
      d[16 +: 16] = 16'h8000; d[80 +: 16] = 16'h8000; send(d, 0);
      // cofactor (1,2) distinct pattern
      d = {16'd9, 16'd8, 16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd10}; send(d, 0);
      d = {16'd1, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0, 16'd3}; send(d, 0);
      d = {16'hfffd, 16'd0, 16'd0, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd3}; send(d, 0);
      stim_started = 1;
      for (int i = 0; i < NUM_RAND; i++) begin
         // back-to-back bursts during the hold-off window so the pipe fills
         send(rand_matrix(), hold_off);
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
